// File: rtl/hpf5_pkg.sv
// Shared types, constants and coefficient table for the fifth-order high-pass filter.
// Used by hpf5_ctrl, hpf5_datapath and highpass_iir_fifth_order; depends on nothing.

package hpf5_pkg;

	// Defaults for the top-level parameters
	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int STATE_FRAC_DEF   = 40;

	// Coefficient format: signed 64-bit words, 40 fraction bits
	localparam int COEF_W    = 64;
	localparam int COEF_FRAC = 40;
	localparam int STATE_W   = 64;
	// Product bits kept before the final slice: state width plus coefficient fraction
	localparam int ACC_W     = STATE_W + COEF_FRAC;
	// Shared multiplier operand width: a 32-bit chunk plus a sign or zero bit
	localparam int MUL_W     = 33;

	localparam int TAPS    = 5;
	localparam int NCOEF   = 16;

	// Coefficient table layout: zi[0..4], b[0..5], a[1..5]
	localparam logic [3:0] C_ZI0 = 4'd0;
	localparam logic [3:0] C_B0  = 4'd5;
	localparam logic [3:0] C_A1  = 4'd11;

	// Product sequence: zi loads, b0, then b_k and a_k interleaved
	localparam logic [3:0] PROD_FIRST = 4'd0;
	localparam logic [3:0] PROD_B0    = 4'd5;
	localparam logic [3:0] PROD_LAST  = 4'd15;
	localparam logic [3:0] TAP_LAST   = 4'd5;

	localparam logic signed [COEF_W-1:0] COEF [NCOEF] = '{
		-64'sd1066483470854,
		64'sd4265933855175,
		-64'sd6398900741259,
		64'sd4265933800394,
		-64'sd1066483443456,
		64'sd1066483007865,
		-64'sd5332415039325,
		64'sd10664830078650,
		-64'sd10664830078650,
		64'sd5332415039325,
		-64'sd1066483007865,
		-64'sd5430489929782,
		64'sd10728884409901,
		-64'sd10598791648398,
		64'sd5235332089428,
		-64'sd1034446546386
	};

	// What to do with a finished, rounded product
	typedef enum logic [2:0] {
		CM_NONE,
		CM_ZI,
		CM_Y,
		CM_TADD,
		CM_TONLY,
		CM_DSUB
	} commit_op_t;

	typedef struct packed {
		commit_op_t op;
		logic [2:0] idx;
	} commit_t;

	localparam commit_t COMMIT_IDLE = '{op: CM_NONE, idx: 3'd0};

	typedef struct packed {
		logic [3:0] coef_sel;
		logic       val_y;
		commit_t    commit;
	} prod_t;

	// Command word from the sequencer to the datapath
	typedef struct packed {
		logic       load_in;
		logic       mul_en;
		logic       mul_first;
		logic [3:0] coef_sel;
		logic       coef_hi;
		logic       val_y;
		logic       val_hi;
		commit_t    commit;
		logic       out_load;
	} dp_cmd_t;

	// Coefficient, operand and follow-up action for each product in the sequence
	function automatic prod_t prod_info(input logic [3:0] p);
		prod_t      info;
		logic [3:0] k;
		info = '{coef_sel: C_B0, val_y: 1'b0, commit: COMMIT_IDLE};
		k    = 4'd0;
		if (p < PROD_B0) begin
			info.coef_sel   = C_ZI0 + p;
			info.commit.op  = CM_ZI;
			info.commit.idx = p[2:0];
		end else if (p == PROD_B0) begin
			info.coef_sel   = C_B0;
			info.commit.op  = CM_Y;
			info.commit.idx = 3'd0;
		end else if (!p[0]) begin
			// b_k * x, added to the old delay term k
			k = (p - PROD_B0 + 4'd1) >> 1;
			info.coef_sel   = C_B0 + k;
			info.commit.op  = (k == TAP_LAST) ? CM_TONLY : CM_TADD;
			info.commit.idx = k[2:0];
		end else begin
			// a_k * y, subtracted into delay term k-1
			k = (p - PROD_B0) >> 1;
			info.coef_sel   = C_A1 + k - 4'd1;
			info.val_y      = 1'b1;
			info.commit.op  = CM_DSUB;
			info.commit.idx = 3'(k - 4'd1);
		end
		return info;
	endfunction

endpackage

// File: rtl/highpass_iir_fifth_order.sv
// Fifth-order Butterworth high-pass, transposed direct form II, one shared 33x33 multiplier.
// One word at a time: in_stall stays high from acceptance until the result is loaded; start_req
// first loads the delays (five extra products). Each product passes through the single
// multiplier as partial products, two per sample product, four per y.
// Reset (arst_n low, asynchronous): delay terms cleared to zero, sequencer idle, no result.
// Depends on hpf5_pkg, hpf5_ctrl and hpf5_datapath.

module highpass_iir_fifth_order #(
	parameter int SAMPLE_WIDTH    = hpf5_pkg::SAMPLE_WIDTH_DEF,
	parameter int STATE_FRAC_BITS = hpf5_pkg::STATE_FRAC_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                           start_req,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] filtered,
	output logic                           saturated
);

	hpf5_pkg::dp_cmd_t cmd;

	// Sequencer
	hpf5_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.start_req (start_req),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// Arithmetic and storage
	hpf5_datapath #(
		.SAMPLE_WIDTH    (SAMPLE_WIDTH),
		.STATE_FRAC_BITS (STATE_FRAC_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sample    (sample),
		.filtered  (filtered),
		.saturated (saturated)
	);

endmodule

// File: rtl/hpf5_ctrl.sv
// Sequencer for the fifth-order high-pass filter: handshakes and the multiply schedule.
// Depends on hpf5_pkg; drives hpf5_datapath through a dp_cmd_t command word.

module hpf5_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               start_req,
	output logic               in_stall,
	input  logic               out_stall,
	output logic               out_valid,
	output hpf5_pkg::dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t              state_q;
	logic [3:0]          pidx_q;
	logic [1:0]          part_q;
	hpf5_pkg::commit_t   pend_s1;
	hpf5_pkg::commit_t   pend_s2;
	logic                out_valid_q;

	hpf5_pkg::prod_t     info;
	logic                last_part;
	logic                accept;
	logic                out_free;
	logic                fin_done;

	// Decode the current product and handshake conditions
	always_comb begin
		info      = hpf5_pkg::prod_info(pidx_q);
		last_part = info.val_y ? (part_q == 2'd3) : (part_q == 2'd1);
		accept    = in_valid && (state_q == ST_IDLE);
		out_free  = !out_valid_q || !out_stall;
		fin_done  = (state_q == ST_FIN) && out_free && (pend_s1.op == hpf5_pkg::CM_NONE);
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// Build the command word; commits trail the last partial by the multiply stage
	// and the accumulate stage
	always_comb begin
		cmd           = '0;
		cmd.load_in   = accept;
		cmd.mul_en    = (state_q == ST_RUN);
		cmd.mul_first = (part_q == 2'd0);
		cmd.coef_sel  = info.coef_sel;
		cmd.val_y     = info.val_y;
		cmd.coef_hi   = info.val_y ? part_q[1] : part_q[0];
		cmd.val_hi    = info.val_y & part_q[0];
		cmd.commit    = pend_s2;
		cmd.out_load  = fin_done;
	end

	// Advance the schedule
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pidx_q  <= hpf5_pkg::PROD_FIRST;
			part_q  <= 2'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						pidx_q  <= start_req ? hpf5_pkg::PROD_FIRST : hpf5_pkg::PROD_B0;
						part_q  <= 2'd0;
					end
				end
				ST_RUN: begin
					if (last_part) begin
						part_q <= 2'd0;
						if (pidx_q == hpf5_pkg::PROD_LAST) begin
							state_q <= ST_FIN;
						end else begin
							pidx_q <= pidx_q + 4'd1;
						end
					end else begin
						part_q <= part_q + 2'd1;
					end
				end
				ST_FIN: begin
					if (fin_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Delay each product's commit until its sum has settled in the accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= hpf5_pkg::COMMIT_IDLE;
			pend_s2 <= hpf5_pkg::COMMIT_IDLE;
		end else begin
			pend_s1 <= ((state_q == ST_RUN) && last_part) ? info.commit
			                                               : hpf5_pkg::COMMIT_IDLE;
			pend_s2 <= pend_s1;
		end
	end

	// Hold the result word until the far side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// A result word is never written over one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result word overwritten while stalled");

	// An accepted word starts either at the zi loads or at b0
	a_start_point: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RUN) && (part_q == 2'd0) &&
		           ((pidx_q == hpf5_pkg::PROD_FIRST) || (pidx_q == hpf5_pkg::PROD_B0)))
		else $error("sequence did not start at a valid product");

	// No commit is left behind when the sequencer goes idle
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |->
		((pend_s1.op == hpf5_pkg::CM_NONE) && (pend_s2.op == hpf5_pkg::CM_NONE)))
		else $error("commit pending while idle");

	// A result only appears after a finished sequence
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(fin_done))
		else $error("result valid without a finished sequence");

endmodule

// File: rtl/hpf5_datapath.sv
// Datapath for the fifth-order high-pass filter: shared multiplier, accumulator,
// delay terms and output rounding. Depends on hpf5_pkg; commanded by hpf5_ctrl.

module hpf5_datapath #(
	parameter int SAMPLE_WIDTH    = hpf5_pkg::SAMPLE_WIDTH_DEF,
	parameter int STATE_FRAC_BITS = hpf5_pkg::STATE_FRAC_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  hpf5_pkg::dp_cmd_t              cmd,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic signed [SAMPLE_WIDTH-1:0] filtered,
	output logic                           saturated
);

	localparam int OUT_SHIFT = STATE_FRAC_BITS - (SAMPLE_WIDTH - 3);
	localparam int MW        = hpf5_pkg::MUL_W;
	localparam int PW        = 2 * MW;
	localparam int AW        = hpf5_pkg::ACC_W;
	localparam int SW        = hpf5_pkg::STATE_W;
	localparam int CF        = hpf5_pkg::COEF_FRAC;
	localparam int HALF      = SW / 2;

	// Partial-product placement: {value is y, coefficient high chunk, value high chunk}
	localparam logic [2:0] POS_X_LO  = 3'b000;
	localparam logic [2:0] POS_X_HI  = 3'b010;
	localparam logic [2:0] POS_Y_LL  = 3'b100;
	localparam logic [2:0] POS_Y_LH  = 3'b101;
	localparam logic [2:0] POS_Y_HL  = 3'b110;
	localparam logic [2:0] POS_Y_HH  = 3'b111;

	localparam logic signed [AW-1:0] ROUND_HALF = AW'(1) <<< (CF - 1);
	localparam logic signed [SW-1:0] SMAX = (SW'(1) <<< (SAMPLE_WIDTH - 1)) - SW'(1);
	localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

	logic signed [SAMPLE_WIDTH-1:0] raw_q;
	logic signed [SW-1:0]           y_q;
	logic signed [SW-1:0]           t_q;
	logic signed [SW-1:0]           delay_q [hpf5_pkg::TAPS];
	logic signed [AW-1:0]           acc_q;

	logic signed [PW-1:0]           pp_s1;
	logic [2:0]                     pos_s1;
	logic                           first_s1;
	logic                           acc_en_s1;

	logic signed [hpf5_pkg::COEF_W-1:0] coef_w;
	logic signed [MW-1:0]           op_c;
	logic signed [MW-1:0]           op_v;
	logic signed [PW-1:0]           pp;
	logic signed [AW-1:0]           pp_ext;
	logic signed [AW-1:0]           shifted;
	logic signed [SW-1:0]           rnd;
	logic signed [SW-1:0]           d_rd;
	logic signed [SW-1:0]           r_out;

	// Hold the accepted sample
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			raw_q <= sample;
		end
	end

	// Pick the operand chunks and multiply
	always_comb begin
		coef_w = hpf5_pkg::COEF[cmd.coef_sel];
		op_c   = cmd.coef_hi ? {coef_w[SW-1], coef_w[SW-1:HALF]}
		                     : {1'b0, coef_w[HALF-1:0]};
		if (cmd.val_y) begin
			op_v = cmd.val_hi ? {y_q[SW-1], y_q[SW-1:HALF]} : {1'b0, y_q[HALF-1:0]};
		end else begin
			op_v = {{(MW - SAMPLE_WIDTH){raw_q[SAMPLE_WIDTH-1]}}, raw_q};
		end
		pp = op_c * op_v;
	end

	// Register the partial product and its placement
	always_ff @(posedge clk) begin
		pp_s1    <= pp;
		pos_s1   <= {cmd.val_y, cmd.coef_hi, cmd.val_hi};
		first_s1 <= cmd.mul_first;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_en_s1 <= 1'b0;
		end else begin
			acc_en_s1 <= cmd.mul_en;
		end
	end

	// Place the partial product; the sample side carries the widening shift
	always_comb begin
		pp_ext = {{(AW - PW){pp_s1[PW-1]}}, pp_s1};
		case (pos_s1)
			POS_X_LO: shifted = pp_ext <<< OUT_SHIFT;
			POS_X_HI: shifted = pp_ext <<< (OUT_SHIFT + HALF);
			POS_Y_LL: shifted = pp_ext;
			POS_Y_LH: shifted = pp_ext <<< HALF;
			POS_Y_HL: shifted = pp_ext <<< HALF;
			POS_Y_HH: shifted = pp_ext <<< SW;
			default:  shifted = pp_ext;
		endcase
	end

	// Accumulate, seeding each product with the rounding half
	always_ff @(posedge clk) begin
		if (acc_en_s1) begin
			acc_q <= (first_s1 ? ROUND_HALF : acc_q) + shifted;
		end
	end

	assign rnd  = acc_q[CF+SW-1:CF];
	assign d_rd = delay_q[cmd.commit.idx];

	// Write finished products into the delay terms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < hpf5_pkg::TAPS; k++) begin
				delay_q[k] <= '0;
			end
		end else begin
			case (cmd.commit.op)
				hpf5_pkg::CM_ZI:   delay_q[cmd.commit.idx] <= rnd;
				hpf5_pkg::CM_DSUB: delay_q[cmd.commit.idx] <= t_q - rnd;
				default: ;
			endcase
		end
	end

	// Form y and the per-tap partial sum
	always_ff @(posedge clk) begin
		case (cmd.commit.op)
			hpf5_pkg::CM_Y:     y_q <= rnd + d_rd;
			hpf5_pkg::CM_TADD:  t_q <= rnd + d_rd;
			hpf5_pkg::CM_TONLY: t_q <= rnd;
			default: ;
		endcase
	end

	// Round y back to the sample format and clip; keep the shift arithmetic
	assign r_out = (y_q >>> OUT_SHIFT) + $signed(SW'(y_q[OUT_SHIFT-1]));

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (r_out > SMAX) begin
				filtered  <= SMAX[SAMPLE_WIDTH-1:0];
				saturated <= 1'b1;
			end else if (r_out < SMIN) begin
				filtered  <= SMIN[SAMPLE_WIDTH-1:0];
				saturated <= 1'b1;
			end else begin
				filtered  <= r_out[SAMPLE_WIDTH-1:0];
				saturated <= 1'b0;
			end
		end
	end

endmodule
